// ===== hw/rtl/hts_pkg.sv =====
// Shared types, constants and tables for the hit to sector and strip mapper.
package hts_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XW           = 27;   // Q.8 coordinate width through both CORDICs
  localparam int ZW           = 34;   // signed residual angle width in the projection CORDIC
  localparam int RW           = 28;   // projected radius width
  localparam int DW           = 18;   // strip divider dividend and quotient width
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 15;

  typedef logic [31:0] angle_t;

  localparam angle_t HALF_TURN    = 32'h8000_0000;
  localparam angle_t QUARTER_TURN = 32'h4000_0000;
  localparam angle_t THREE_QUARTER_TURN = 32'hC000_0000;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // sector shift in turn units: 119304*s + (23296*s + 18000) / 36000
  localparam logic [16:0] SHIFT_INT   = 17'd119304;
  localparam logic [24:0] SHIFT_FRAC  = 25'd23296;
  localparam logic [24:0] SHIFT_ROUND = 25'd18000;
  localparam logic [24:0] SHIFT_DIV   = 25'd36000;
  localparam logic [24:0] SHIFT_RECIP = 25'd30541989;   // floor(2^40 / 36000)

  localparam angle_t ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_RADIUS = 3'd0,
    REG_STRIP_PITCH  = 3'd1,
    REG_STRIP_WIDTH  = 3'd2,
    REG_EDGE_MARGIN  = 3'd3,
    REG_SECTOR_SHIFT = 3'd4
  } cfg_reg_e;

endpackage

// ===== hw/rtl/hit_to_sector_and_strip.sv =====
// Hit to sector and strip mapper: CORDIC angle, sector pick, axis projection, strip pick.
// Pipeline: 74 register stages from the input stage to the output register.
// One hit per cycle unless stalled; two 24-step CORDICs and an 18-stage strip divider.
// The whole pipeline advances when the output register is empty or taken; otherwise it holds.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
// A sector shift write reaches shift_turn_q through the sh_num_q and sh_prod_q registers.
module hit_to_sector_and_strip #(
  parameter int MODULE_COUNT = 50,
  parameter int STRIP_COUNT  = 33
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [hts_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // hit_x[16:0], hit_y[33:17]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [hts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // module_index[5:0], strip_index[11:6]
  output logic [0:0]                         m_axis_tuser,   // hit_valid[0]
  input  logic                               cfg_we_i,
  input  logic [hts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hts_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int NS  = hts_pkg::CORDIC_STEPS;
  localparam int XW  = hts_pkg::XW;
  localparam int ZW  = hts_pkg::ZW;
  localparam int RW  = hts_pkg::RW;
  localparam int DW  = hts_pkg::DW;
  localparam int MW  = $clog2(MODULE_COUNT);
  localparam int MCW = $clog2(MODULE_COUNT + 1);
  localparam int SW  = $clog2(STRIP_COUNT + 1);
  localparam int LAT = 2 * NS + DW + 8;

  // configuration
  logic [14:0] first_radius_q;
  logic [9:0]  strip_pitch_q;
  logic [9:0]  strip_width_q;
  logic [7:0]  edge_margin_q;
  logic [9:0]  sector_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_radius_q <= 15'd16530;
      strip_pitch_q  <= 10'd448;
      strip_width_q  <= 10'd400;
      edge_margin_q  <= 8'd48;
      sector_shift_q <= 10'd360;
    end else if (cfg_we_i) begin
      unique case (hts_pkg::cfg_reg_e'(cfg_idx_i))
        hts_pkg::REG_FIRST_RADIUS: first_radius_q <= cfg_data_i[14:0];
        hts_pkg::REG_STRIP_PITCH:  strip_pitch_q  <= cfg_data_i[9:0];
        hts_pkg::REG_STRIP_WIDTH:  strip_width_q  <= cfg_data_i[9:0];
        hts_pkg::REG_EDGE_MARGIN:  edge_margin_q  <= cfg_data_i[7:0];
        hts_pkg::REG_SECTOR_SHIFT: sector_shift_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // sector shift in turn units
  logic [24:0] sh_num;
  logic [24:0] sh_num_q;
  logic [49:0] sh_prod_q;
  logic [9:0]  sh_qe;
  logic [25:0] sh_chk;
  logic [9:0]  sh_q;
  hts_pkg::angle_t shift_turn_d, shift_turn_q;

  assign sh_num = 25'(25'(sector_shift_q) * hts_pkg::SHIFT_FRAC) + hts_pkg::SHIFT_ROUND;

  always_comb begin
    sh_qe  = sh_prod_q[49:40];
    sh_chk = 26'({1'b0, sh_num_q}) - 26'(26'(sh_qe) * 26'(hts_pkg::SHIFT_DIV));
    sh_q   = (sh_chk >= 26'(hts_pkg::SHIFT_DIV)) ? sh_qe + 10'd1 : sh_qe;
    shift_turn_d = 32'(32'(sector_shift_q) * 32'(hts_pkg::SHIFT_INT)) + 32'(sh_q);
  end

  always_ff @(posedge clk_i) begin
    sh_num_q     <= sh_num;
    sh_prod_q    <= 50'(sh_num) * 50'(hts_pkg::SHIFT_RECIP);
    shift_turn_q <= shift_turn_d;
  end

  // handshake and valid chain
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // input stage: Q.8 scaling and half-plane fold
  logic signed [16:0]    hx_in, hy_in;
  logic signed [XW-1:0]  x_in8, y_in8;

  assign hx_in = s_axis_tdata[16:0];
  assign hy_in = s_axis_tdata[33:17];
  assign x_in8 = $signed({{(XW-25){hx_in[16]}}, hx_in, 8'd0});
  assign y_in8 = $signed({{(XW-25){hy_in[16]}}, hy_in, 8'd0});

  logic signed [XW-1:0] vx_q [NS+1];
  logic signed [XW-1:0] vy_q [NS+1];
  hts_pkg::angle_t      vz_q [NS+1];
  logic signed [16:0]   hx_q [NS+1];
  logic signed [16:0]   hy_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hx_q[0] <= hx_in;
      hy_q[0] <= hy_in;
      if (x_in8 < 0) begin
        vx_q[0] <= -x_in8;
        vy_q[0] <= -y_in8;
        vz_q[0] <= hts_pkg::HALF_TURN;
      end else begin
        vx_q[0] <= x_in8;
        vy_q[0] <= y_in8;
        vz_q[0] <= '0;
      end
    end
  end

  // vectoring CORDIC
  for (genvar g = 0; g < NS; g++) begin : g_vec
    logic signed [XW-1:0] dx, dy;
    assign dx = vy_q[g] >>> g;
    assign dy = vx_q[g] >>> g;
    always_ff @(posedge clk_i) begin
      if (en) begin
        hx_q[g+1] <= hx_q[g];
        hy_q[g+1] <= hy_q[g];
        if (vy_q[g] > 0) begin
          vx_q[g+1] <= vx_q[g] + dx;
          vy_q[g+1] <= vy_q[g] - dy;
          vz_q[g+1] <= vz_q[g] + hts_pkg::ATAN_TURN[g];
        end else begin
          vx_q[g+1] <= vx_q[g] - dx;
          vy_q[g+1] <= vy_q[g] + dy;
          vz_q[g+1] <= vz_q[g] - hts_pkg::ATAN_TURN[g];
        end
      end
    end
  end

  // sector shift, then module number
  hts_pkg::angle_t    ang_q;
  logic signed [16:0] ahx_q, ahy_q, mhx_q, mhy_q;
  logic [MW-1:0]      mod_q;
  logic [32+MCW-1:0]  mod_prod;

  assign mod_prod = (32+MCW)'(ang_q) * (32+MCW)'(MODULE_COUNT);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q <= vz_q[NS] + shift_turn_q;
      ahx_q <= hx_q[NS];
      ahy_q <= hy_q[NS];
      mod_q <= mod_prod[32 +: MW];
      mhx_q <= ahx_q;
      mhy_q <= ahy_q;
    end
  end

  // module centre angles
  hts_pkg::angle_t ctr_tab [2**MW];
  for (genvar g = 0; g < 2**MW; g++) begin : g_ctr
    localparam logic [63:0] CV = (g < MODULE_COUNT) ?
      ((64'(g) << 32) + 64'(MODULE_COUNT / 2)) / 64'(MODULE_COUNT) : 64'd0;
    assign ctr_tab[g] = CV[31:0];
  end

  // projection setup: rotate by minus centre, fold into the right half-turn
  hts_pkg::angle_t      rot_d, rot_f;
  logic                 fold;
  logic signed [XW-1:0] mx8, my8;

  assign rot_d = 32'd0 - ctr_tab[mod_q];
  assign fold  = (rot_d >= hts_pkg::QUARTER_TURN) && (rot_d < hts_pkg::THREE_QUARTER_TURN);
  assign rot_f = fold ? rot_d - hts_pkg::HALF_TURN : rot_d;
  assign mx8   = $signed({{(XW-25){mhx_q[16]}}, mhx_q, 8'd0});
  assign my8   = $signed({{(XW-25){mhy_q[16]}}, mhy_q, 8'd0});

  logic signed [XW-1:0] px_q [NS+1];
  logic signed [XW-1:0] py_q [NS+1];
  logic signed [ZW-1:0] pz_q [NS+1];
  logic [MW-1:0]        pm_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= fold ? -mx8 : mx8;
      py_q[0] <= fold ? -my8 : my8;
      pz_q[0] <= $signed({{(ZW-32){rot_f[31]}}, rot_f});
      pm_q[0] <= mod_q;
    end
  end

  // rotating CORDIC
  for (genvar g = 0; g < NS; g++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = py_q[g] >>> g;
    assign dy = px_q[g] >>> g;
    assign at = $signed({{(ZW-32){1'b0}}, hts_pkg::ATAN_TURN[g]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        pm_q[g+1] <= pm_q[g];
        if (pz_q[g] >= 0) begin
          px_q[g+1] <= px_q[g] - dx;
          py_q[g+1] <= py_q[g] + dy;
          pz_q[g+1] <= pz_q[g] - at;
        end else begin
          px_q[g+1] <= px_q[g] + dx;
          py_q[g+1] <= py_q[g] - dy;
          pz_q[g+1] <= pz_q[g] + at;
        end
      end
    end
  end

  // gain compensation
  logic signed [XW+16:0] gp_q;
  logic [MW-1:0]         gm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      gp_q <= (XW+17)'(px_q[NS]) * $signed({1'b0, hts_pkg::INV_GAIN_Q16});
      gm_q <= pm_q[NS];
    end
  end

  // bank bounds and strip offset
  logic signed [RW-1:0] rad, lo, hi, toff, wq8;
  logic signed [19:0]   hi_mm;
  logic                 in_bank, below_w;
  logic [9:0]           pe;
  logic [DW-1:0]        tt;

  assign pe      = (strip_pitch_q == 10'd0) ? 10'd1 : strip_pitch_q;
  assign rad     = gp_q[XW+16:16];
  assign hi_mm   = 20'(20'(first_radius_q) + 20'(20'(STRIP_COUNT - 1) * 20'(strip_pitch_q))
                   + 20'(strip_width_q)) - 20'(edge_margin_q);
  assign lo      = $signed({{(RW-24){1'b0}}, 16'(16'(first_radius_q) + 16'(edge_margin_q)), 8'd0});
  assign hi      = $signed({hi_mm, 8'd0});
  assign wq8     = $signed({{(RW-18){1'b0}}, strip_width_q, 8'd0});
  assign toff    = rad - $signed({{(RW-23){1'b0}}, first_radius_q, 8'd0});
  assign in_bank = (rad >= lo) && (rad <= hi);
  assign below_w = toff < wq8;
  assign tt      = toff[DW+7:8];

  // strip dividers: j = t / pitch, i = (t - width) / pitch, one quotient bit a stage
  logic [DW-1:0]        jn_q [DW+1];
  logic [DW-1:0]        in_q [DW+1];
  logic [9:0]           jr_q [DW+1];
  logic [9:0]           ir_q [DW+1];
  logic signed [RW-1:0] dt_q [DW+1];
  logic                 dv_q [DW+1];
  logic                 dw_q [DW+1];
  logic [MW-1:0]        dm_q [DW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      jn_q[0] <= in_bank ? tt : '0;
      in_q[0] <= (in_bank && !below_w) ? tt - DW'(strip_width_q) : '0;
      jr_q[0] <= '0;
      ir_q[0] <= '0;
      dt_q[0] <= toff;
      dv_q[0] <= in_bank;
      dw_q[0] <= below_w;
      dm_q[0] <= gm_q;
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_div
    logic [10:0] rj, ri;
    assign rj = {jr_q[g], jn_q[g][DW-1]};
    assign ri = {ir_q[g], in_q[g][DW-1]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        dt_q[g+1] <= dt_q[g];
        dv_q[g+1] <= dv_q[g];
        dw_q[g+1] <= dw_q[g];
        dm_q[g+1] <= dm_q[g];
        if (rj >= {1'b0, pe}) begin
          jr_q[g+1] <= 10'(rj - {1'b0, pe});
          jn_q[g+1] <= {jn_q[g][DW-2:0], 1'b1};
        end else begin
          jr_q[g+1] <= rj[9:0];
          jn_q[g+1] <= {jn_q[g][DW-2:0], 1'b0};
        end
        if (ri >= {1'b0, pe}) begin
          ir_q[g+1] <= 10'(ri - {1'b0, pe});
          in_q[g+1] <= {in_q[g][DW-2:0], 1'b1};
        end else begin
          ir_q[g+1] <= ri[9:0];
          in_q[g+1] <= {in_q[g][DW-2:0], 1'b0};
        end
      end
    end
  end

  // candidate strips and their start offsets
  logic [DW:0]          i0;
  logic [SW-1:0]        i0c_q, jc_q;
  logic [SW+9:0]        i0p_q, jp_q;
  logic                 i0ok_q, jlast_q, sv_q;
  logic signed [RW-1:0] st_q;
  logic [MW-1:0]        sm_q;

  assign i0 = dw_q[DW] ? '0 : {1'b0, in_q[DW]} + (DW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      i0c_q   <= i0[SW-1:0];
      jc_q    <= jn_q[DW][SW-1:0];
      i0p_q   <= (SW+10)'(i0[SW-1:0]) * (SW+10)'(pe);
      jp_q    <= (SW+10)'(jn_q[DW][SW-1:0]) * (SW+10)'(pe);
      i0ok_q  <= i0 < (DW+1)'(STRIP_COUNT);
      jlast_q <= jn_q[DW] >= DW'(STRIP_COUNT - 1);
      sv_q    <= dv_q[DW];
      st_q    <= dt_q[DW];
      sm_q    <= dm_q[DW];
    end
  end

  // final strip choice and output register
  logic [SW+18:0] mid;
  logic [SW-1:0]  strip_d;
  logic [MW-1:0]  out_mod_q;
  logic [SW-1:0]  out_strip_q;
  logic           out_hv_q;

  assign mid = {1'b0, jp_q, 8'd0} + (SW+19)'({pe, 7'd0}) + (SW+19)'({strip_width_q, 7'd0});

  always_comb begin
    if (!sv_q) begin
      strip_d = '0;
    end else if (i0ok_q && ($signed(RW'(i0p_q)) <= (st_q >>> 8))) begin
      strip_d = i0c_q;
    end else if (jlast_q) begin
      strip_d = SW'(STRIP_COUNT - 1);
    end else if (st_q <= $signed(RW'(mid))) begin
      strip_d = jc_q;
    end else begin
      strip_d = jc_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mod_q   <= sm_q;
      out_strip_q <= strip_d;
      out_hv_q    <= sv_q;
    end
  end

  assign m_axis_tdata = {4'd0, 6'(out_strip_q), 6'(out_mod_q)};
  assign m_axis_tuser = out_hv_q;

endmodule

// ===== hw/rtl/hts_checker.sv =====
// Port-level checker for the hit to sector and strip mapper, bound to the top level.
module hts_checker #(
  parameter int MODULE_COUNT = 50,
  parameter int STRIP_COUNT  = 33
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [hts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // output taken or empty means input side open
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
    else $error("input blocked with free output");

  a_strip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[11:6] == 6'd0)
    else $error("strip set on invalid hit");

  a_module_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (MODULE_COUNT > 64) || (int'(m_axis_tdata[5:0]) < MODULE_COUNT))
    else $error("module out of range");

  a_strip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (STRIP_COUNT > 64) || (int'(m_axis_tdata[11:6]) < STRIP_COUNT))
    else $error("strip out of range");

endmodule

bind hit_to_sector_and_strip hts_checker #(
  .MODULE_COUNT(MODULE_COUNT),
  .STRIP_COUNT (STRIP_COUNT)
) u_hts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
